// ===== rtl/core/mec_pkg.sv =====
// ----------------------------------------------------------------------------
// mec_pkg
// types and constants shared by the modular exponentiation compare block
// ----------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

  localparam int unsigned FieldWidth = 32;

  typedef struct packed {
    logic [FieldWidth-1:0] base_value;
    logic [FieldWidth-1:0] exponent_value;
    logic [FieldWidth-1:0] expected;
  } mec_req_t;

  typedef struct packed {
    logic [FieldWidth-1:0] power;
    logic                  matches_res;
  } mec_res_t;

  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StMul,
    StSqr,
    StDone
  } mec_state_e;

  typedef struct packed {
    logic load;
    logic red_start;
    logic mul_start;
    logic sqr_start;
    logic emit;
  } mec_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic exp_bit;
    logic last_bit;
  } mec_sts_t;

  localparam logic [0:0] RegModulus = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/core/modular_exponentiation_compare_top.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_compare_top
// square-and-multiply modular exponentiation with compare against expected
// ----------------------------------------------------------------------------
// channel   signals                         direction
// request   start, busy (out), req_i            in
// result    res_valid_o, res_o              out
// config    psel/penable/pwrite/paddr/...   apb
//
// a request scans exponent bits from the lowest up to the highest set bit (at
// least one): a reduce of the base first, then per bit a multiply if the bit
// is set and a square unless it is the last; each reduce, multiply or
// square is a shift-and-add pass in the single shared unit. busy drops in
// the result cycle. reset sets modulus to 2; no clearing pass. results are
// strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_compare_top import mec_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire mec_req_t    req_i,
  output logic             res_valid_o,
  output mec_res_t         res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned W = OPERAND_WIDTH;

  logic [W-1:0] modulus_q;
  logic [W-1:0] wval;
  mec_cmd_t     cmd;
  mec_sts_t     sts;
  logic         cfg_wr;

  assign wval   = pwdata[W-1:0];
  assign cfg_wr = psel && penable && pwrite && (paddr == RegModulus);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= W'(2);
    end else if (cfg_wr && (wval[W-1:1] != '0)) begin
      modulus_q <= wval;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == RegModulus) ? 32'(modulus_q) : '0;

  mec_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  mec_datapath #(.W(W)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .modulus_i   (modulus_q),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  a_modulus_ge2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    modulus_q[W-1:1] != '0) else $error("modulus below two");

  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy)) else $error("result without request");

  a_power_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.power < FieldWidth'(modulus_q)) else $error("power not reduced");

endmodule

`default_nettype wire

// ===== rtl/core/mec_modmul.sv =====
// ----------------------------------------------------------------------------
// mec_modmul
// shift-and-add modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mec_modmul import mec_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] m_i,
  output logic              done_o,
  output logic [W-1:0]      p_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    a_q, a_d;
  logic [W-1:0]    b_q, b_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [W:0]      dbl, dbl_r, add, add_r;

  // a is reduced below m by the caller; acc stays below m
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    add   = dbl_r + {1'b0, a_q};
    add_r = (add >= {1'b0, m_i}) ? add - {1'b0, m_i} : add;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = b_q[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
      b_d   = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/mec_datapath.sv =====
// ----------------------------------------------------------------------------
// mec_datapath
// operand registers, exponent shifter and shared modular multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module mec_datapath import mec_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire mec_cmd_t     cmd_i,
  input  wire mec_req_t     req_i,
  input  wire logic [W-1:0] modulus_i,
  output mec_sts_t          sts_o,
  output logic              res_valid_o,
  output mec_res_t          res_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  typedef enum logic [1:0] {DstRed, DstAcc, DstSq} dst_e;

  logic [W-1:0]    acc_q, sq_q, exp_q, exp_x_q;
  logic [CntW-1:0] bits_q;
  logic            mul_start, mul_done;
  logic [W-1:0]    mul_a, mul_b, mul_p;
  logic            res_valid_q;
  mec_res_t        res_q;
  logic [W:0]      base_r;
  dst_e            dst_q;

  // reduction of the base is a multiply by one
  always_comb begin
    mul_start = cmd_i.red_start || cmd_i.mul_start || cmd_i.sqr_start;
    mul_a = sq_q;
    mul_b = sq_q;
    if (cmd_i.red_start) begin
      mul_a = W'(1);
      mul_b = sq_q;
    end else if (cmd_i.mul_start) begin
      mul_b = acc_q;
    end
  end

  mec_modmul #(.W(W)) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (modulus_i),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // sq_q holds the base less at most one m at load: force it below m via reduce step
  assign base_r = {1'b0, req_i.base_value[W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_q <= DstRed;
    end else if (cmd_i.red_start) begin
      dst_q <= DstRed;
    end else if (cmd_i.mul_start) begin
      dst_q <= DstAcc;
    end else if (cmd_i.sqr_start) begin
      dst_q <= DstSq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q   <= W'(1);
      sq_q    <= (base_r >= {1'b0, modulus_i}) ? W'(base_r - {1'b0, modulus_i})
                                               : base_r[W-1:0];
      exp_q   <= req_i.exponent_value[W-1:0];
      exp_x_q <= req_i.expected[W-1:0];
      bits_q  <= CntW'(W);
    end else if (mul_done) begin
      unique case (dst_q)
        DstAcc:  acc_q <= mul_p;
        DstSq: begin
          sq_q   <= mul_p;
          exp_q  <= exp_q >> 1;
          bits_q <= bits_q - 1'b1;
        end
        default: sq_q <= mul_p;
      endcase
    end
  end

  assign sts_o.unit_done = mul_done;
  assign sts_o.exp_bit   = exp_q[0];
  assign sts_o.last_bit  = (bits_q == CntW'(1)) || (exp_q[W-1:1] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.power       <= FieldWidth'(acc_q);
      res_q.matches_res <= (acc_q == exp_x_q);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/mec_ctrl.sv =====
// ----------------------------------------------------------------------------
// mec_ctrl
// sequencer for reduce, multiply and square steps
// ----------------------------------------------------------------------------
`default_nettype none

module mec_ctrl import mec_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire mec_sts_t sts_i,
  output mec_cmd_t      cmd_o,
  output logic          busy_o
);

  mec_state_e state_q, state_d;
  logic       issued_q, issued_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  // issued_q: the current step's multiply has been launched
  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    cmd_o    = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StReduce;
          issued_d   = 1'b0;
        end
      end
      StReduce: begin
        if (!issued_q) begin
          cmd_o.red_start = 1'b1;
          issued_d        = 1'b1;
        end else if (sts_i.unit_done) begin
          issued_d = 1'b0;
          state_d  = StMul;
        end
      end
      StMul: begin
        if (!issued_q) begin
          if (sts_i.exp_bit) begin
            cmd_o.mul_start = 1'b1;
            issued_d        = 1'b1;
          end else if (sts_i.last_bit) begin
            state_d = StDone;
          end else begin
            state_d = StSqr;
          end
        end else if (sts_i.unit_done) begin
          issued_d = 1'b0;
          state_d  = sts_i.last_bit ? StDone : StSqr;
        end
      end
      StSqr: begin
        if (!issued_q) begin
          cmd_o.sqr_start = 1'b1;
          issued_d        = 1'b1;
        end else if (sts_i.unit_done) begin
          issued_d = 1'b0;
          state_d  = StMul;
        end
      end
      StDone: begin
        cmd_o.emit = 1'b1;
        state_d    = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  property p_one_cmd;
    @(posedge clk_i) disable iff (!rst_ni)
      $onehot0({cmd_o.load, cmd_o.red_start, cmd_o.mul_start, cmd_o.sqr_start, cmd_o.emit});
  endproperty
  a_one_cmd: assert property (p_one_cmd) else $error("more than one command");

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == StIdle) else $error("emit not followed by idle");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == StReduce) else $error("load not followed by reduce");

endmodule

`default_nettype wire
